// ===== sv/lpdt_pkg.sv =====
// Shared types and constants for the linear probe digest table.
package lpdt_pkg;

  localparam int KEY_FULL_W = 256;
  localparam int REF_W      = 32;
  localparam int OCC_W      = 16;
  localparam int WORD_W     = 64;
  localparam int WORD3_W    = 48;

  localparam int HASH_DIGIT_W = 16;
  localparam int HASH_CYCLES  = 2 * WORD_W / HASH_DIGIT_W;
  localparam int HASH_CNT_W   = $clog2(HASH_CYCLES);

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK
  } lpdt_state_t;

endpackage

// ===== sv/lpdt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lpdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/linear_probe_digest_table.sv =====
// Linear probe digest table: open-addressed key store with linear probing.
// Each accepted key is probed one slot at a time from its start slot until an empty slot or a match;
// the start slot is reduced from key word 0 by the hash steps when SLOTS is not a power of two.
// A new key is accepted only in idle, so one item is handled at a time; one RAM read port serves the probes.
// Reset: synchronous; then a clearing pass over all SLOTS slots, stall held high.
module linear_probe_digest_table #(
  parameter int SLOTS     = 1024,
  parameter int KEY_BYTES = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [47:0] in_key_word3,
  input  logic [31:0] in_new_ref,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_found_ref,
  output logic        out_status,
  output logic [15:0] out_occupancy
);

  localparam int  SW     = $clog2(SLOTS);
  localparam int  KW     = 8 * KEY_BYTES;
  localparam int  EW     = KW + lpdt_pkg::REF_W + 1;
  localparam bit  POW2   = (SLOTS & (SLOTS - 1)) == 0;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
  localparam logic [lpdt_pkg::HASH_CNT_W-1:0] HASH_LAST =
    lpdt_pkg::HASH_CNT_W'(lpdt_pkg::HASH_CYCLES - 1);
  localparam logic [32:0] HASH_MAGIC = 33'((65'd1 << (32 + SW)) / SLOTS + 1);

  lpdt_pkg::lpdt_state_t state_r, state_nxt;

  logic [SW-1:0]  slot_r, slot_nxt;
  logic [SW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  hash_r, hash_nxt;
  logic [63:0]    hash_sh_r, hash_sh_nxt;
  logic [15:0]    hash_q_r, hash_q_nxt;
  logic [lpdt_pkg::HASH_CNT_W-1:0] hash_cnt_r, hash_cnt_nxt;

  logic           req_r;
  logic [63:0]    key0_r, key1_r, key2_r;
  logic [47:0]    key3_r;
  logic [31:0]    ref_r;

  logic           out_valid_r, out_valid_nxt;
  logic           out_hit_r, out_hit_nxt;
  logic [31:0]    out_found_ref_r, out_found_ref_nxt;
  logic           out_status_r, out_status_nxt;
  logic [15:0]    out_occupancy_r, out_occupancy_nxt;

  logic                  ram_we;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;
  logic [lpdt_pkg::KEY_FULL_W-1:0] key_full;
  logic [KW-1:0]         key_cmp;
  logic                  rd_valid;
  logic [31:0]           rd_ref;
  logic                  key_eq;
  logic                  hit;
  logic                  done;
  logic                  out_free;
  logic                  fire;
  logic                  room;
  logic                  accept;
  logic [SW-1:0]         slot_inc;
  logic [SW-1:0]         hash_step;
  logic [15:0]           hash_quot;

  assign key_full = {16'b0, key3_r, key2_r, key1_r, key0_r};
  assign key_cmp  = key_full[KW-1:0];
  assign rd_valid = ram_rdata[EW-1];
  assign rd_ref   = ram_rdata[EW-2 -: lpdt_pkg::REF_W];
  assign key_eq   = ram_rdata[KW-1:0] == key_cmp;
  assign hit      = rd_valid && key_eq;
  assign done     = !rd_valid || key_eq;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == lpdt_pkg::ST_CHECK) && done && out_free;
  assign room     = count_r < LAST;
  assign accept   = (state_r == lpdt_pkg::ST_IDLE) && in_valid;
  assign slot_inc = (slot_r == LAST) ? '0 : slot_r + 1'b1;

  assign in_stall      = state_r != lpdt_pkg::ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_found_ref = out_found_ref_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  // Reduce the digest word 16 bits at a time, most significant first: first the
  // quotient by reciprocal multiply, then the remainder by multiply and subtract.
  always_comb begin
    logic [31:0] t;
    logic [64:0] prod;
    logic [32:0] qm;
    logic [31:0] rem;
    t         = {16'(hash_r), hash_sh_r[63 -: lpdt_pkg::HASH_DIGIT_W]};
    prod      = 65'(t) * 65'(HASH_MAGIC);
    hash_quot = prod[32 + SW +: 16];
    qm        = 33'(hash_q_r) * 33'(SLOTS);
    rem       = t - qm[31:0];
    hash_step = rem[SW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpdt_pkg::ST_CLEAR: begin
        if (slot_r == LAST) begin
          state_nxt = lpdt_pkg::ST_IDLE;
        end
      end
      lpdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = POW2 ? lpdt_pkg::ST_CHECK : lpdt_pkg::ST_HASH;
        end
      end
      lpdt_pkg::ST_HASH: begin
        if (hash_cnt_r == HASH_LAST) begin
          state_nxt = lpdt_pkg::ST_CHECK;
        end
      end
      lpdt_pkg::ST_CHECK: begin
        if (fire) begin
          state_nxt = lpdt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpdt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    slot_nxt          = slot_r;
    count_nxt         = count_r;
    hash_nxt          = hash_r;
    hash_sh_nxt       = hash_sh_r;
    hash_q_nxt        = hash_q_r;
    hash_cnt_nxt      = hash_cnt_r;
    ram_we            = 1'b0;
    ram_wdata         = {1'b1, ref_r, key_cmp};
    out_valid_nxt     = out_valid_r && out_stall;
    out_hit_nxt       = out_hit_r;
    out_found_ref_nxt = out_found_ref_r;
    out_status_nxt    = out_status_r;
    out_occupancy_nxt = out_occupancy_r;
    case (state_r)
      lpdt_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        slot_nxt  = slot_inc;
      end
      lpdt_pkg::ST_IDLE: begin
        if (in_valid) begin
          slot_nxt     = POW2 ? in_key_word0[SW-1:0] : slot_r;
          hash_nxt     = '0;
          hash_sh_nxt  = in_key_word0;
          hash_cnt_nxt = '0;
        end
      end
      lpdt_pkg::ST_HASH: begin
        hash_cnt_nxt = hash_cnt_r + 1'b1;
        if (!hash_cnt_r[0]) begin
          hash_q_nxt = hash_quot;
        end else begin
          hash_nxt    = hash_step;
          hash_sh_nxt = hash_sh_r << lpdt_pkg::HASH_DIGIT_W;
        end
        if (hash_cnt_r == HASH_LAST) begin
          slot_nxt = hash_step;
        end
      end
      lpdt_pkg::ST_CHECK: begin
        if (!done) begin
          slot_nxt = slot_inc;
        end else if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_hit_nxt       = hit;
          out_found_ref_nxt = hit ? rd_ref : '0;
          out_status_nxt    = lpdt_pkg::STATUS_DONE;
          if (req_r == lpdt_pkg::REQ_INSERT) begin
            if (hit) begin
              ram_we = 1'b1;
            end else if (room) begin
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              out_status_nxt = lpdt_pkg::STATUS_FULL;
            end
          end
          out_occupancy_nxt = lpdt_pkg::OCC_W'(count_nxt);
        end
      end
      default: begin
        slot_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpdt_pkg::ST_CLEAR;
      slot_r      <= '0;
      count_r     <= '0;
      hash_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      hash_cnt_r  <= hash_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r          <= hash_nxt;
    hash_sh_r       <= hash_sh_nxt;
    hash_q_r        <= hash_q_nxt;
    out_hit_r       <= out_hit_nxt;
    out_found_ref_r <= out_found_ref_nxt;
    out_status_r    <= out_status_nxt;
    out_occupancy_r <= out_occupancy_nxt;
    if (accept) begin
      req_r  <= in_req_type;
      key0_r <= in_key_word0;
      key1_r <= in_key_word1;
      key2_r <= in_key_word2;
      key3_r <= in_key_word3;
      ref_r  <= in_new_ref;
    end
  end

  lpdt_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(ram_wdata),
    .raddr(slot_nxt),
    .rdata(ram_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST)
    else $error("occupancy beyond table limit");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == lpdt_pkg::ST_CLEAR || state_r == lpdt_pkg::ST_CHECK))
    else $error("slot write outside clear or probe");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1))
    else $error("occupancy moved by other than one");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lpdt_pkg::ST_CHECK))
    else $error("result raised outside probe");

  a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_status_r == lpdt_pkg::STATUS_FULL && out_hit_r))
    else $error("full status on a hit");

endmodule
